>>> rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros
// Assertion macros used by the top-level RTL file of the LED matrix scan driver.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: the consequent holds in the same cycle.
`define LMS_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication: the consequent holds in the next cycle.
`define LMS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/lms_pkg.sv
// ----------------------------------------------------------------------------
// lms_pkg
// Types, constants and helper functions of the LED matrix scan driver.
// ----------------------------------------------------------------------------
package lms_pkg;

    localparam int MATRIX_SIZE = 8;
    localparam int FRAME_BITS  = MATRIX_SIZE * MATRIX_SIZE * 3;
    localparam int HDR_LEN     = 4;
    localparam int PKT_LEN     = HDR_LEN + FRAME_BITS;
    localparam int BUS_W       = 8;

    localparam int POS_W = $clog2(MATRIX_SIZE);
    localparam int IDX_W = $clog2(FRAME_BITS);
    localparam int CNT_W = $clog2(PKT_LEN + 1);

    localparam logic MODE_TICK = 1'b0;
    localparam logic MODE_BYTE = 1'b1;

    typedef enum logic [1:0] {
        STB_RED   = 2'd0,
        STB_GREEN = 2'd1,
        STB_BLUE  = 2'd2,
        STB_ROW   = 2'd3
    } lms_strobe_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_SHORT   = 2'd1,
        ST_BAD_HDR = 2'd2
    } lms_status_t;

    // Current scan position, taken before the step counter advances.
    typedef struct packed {
        lms_strobe_t             phase;
        logic [POS_W-1:0]        col;
        logic [POS_W-1:0]        row;
        logic [IDX_W-1:0]        idx;
        logic                    wrap;
    } lms_scan_pos_t;

    // Write into the receive half of the frame memory.
    typedef struct packed {
        logic                    en;
        logic                    bank;
        logic [IDX_W-1:0]        idx;
        logic                    data;
    } lms_ram_wr_t;

    // Packet receiver outcome for the byte being accepted.
    typedef struct packed {
        logic                    done;
        lms_status_t             status;
    } lms_rx_res_t;

    function automatic logic [7:0] hdr_byte(input logic [1:0] pos);
        logic [7:0] b;
        case (pos)
            2'd0:    b = 8'h42;   // 'B'
            2'd1:    b = 8'h50;   // 'P'
            2'd2:    b = 8'h53;   // 'S'
            default: b = 8'h57;   // 'W'
        endcase
        return b;
    endfunction

    // Level of the eight visible bus lines for one scan step.
    function automatic logic [BUS_W-1:0] bus_levels(input lms_strobe_t phase,
                                                    input logic [POS_W-1:0] col,
                                                    input logic [POS_W-1:0] row,
                                                    input logic lit);
        logic [BUS_W-1:0] b;
        for (int k = 0; k < BUS_W; k++) begin
            if (phase == STB_ROW) begin
                b[k] = (int'(row) == k);
            end else begin
                b[k] = (k < MATRIX_SIZE) && !(lit && (int'(col) == k));
            end
        end
        return b;
    endfunction

endpackage

>>> rtl/core/lms_scan_ctr.sv
// ----------------------------------------------------------------------------
// lms_scan_ctr
// Scan position counters: phase, column, row and the frame bit index.
// ----------------------------------------------------------------------------
module lms_scan_ctr (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   tick,
    output lms_pkg::lms_scan_pos_t pos
);
    import lms_pkg::*;

    lms_strobe_t      phase_reg, phase_next;
    logic [POS_W-1:0] col_reg, col_next;
    logic [POS_W-1:0] row_reg, row_next;
    logic [IDX_W-1:0] base_reg, base_next;
    logic             wrap;

    assign wrap = (phase_reg == STB_ROW) && (col_reg == POS_W'(MATRIX_SIZE - 1))
                  && (row_reg == POS_W'(MATRIX_SIZE - 1));

    always_comb begin
        phase_next = phase_reg;
        col_next   = col_reg;
        row_next   = row_reg;
        base_next  = base_reg;
        if (tick) begin
            if (phase_reg != STB_ROW) begin
                phase_next = lms_strobe_t'(phase_reg + 2'd1);
            end else begin
                phase_next = STB_RED;
                base_next  = IDX_W'(base_reg + IDX_W'(3));
                if (col_reg != POS_W'(MATRIX_SIZE - 1)) begin
                    col_next = POS_W'(col_reg + POS_W'(1));
                end else begin
                    col_next = '0;
                    if (row_reg != POS_W'(MATRIX_SIZE - 1)) begin
                        row_next = POS_W'(row_reg + POS_W'(1));
                    end else begin
                        row_next  = '0;
                        base_next = '0;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= STB_RED;
            col_reg   <= '0;
            row_reg   <= '0;
            base_reg  <= '0;
        end else begin
            phase_reg <= phase_next;
            col_reg   <= col_next;
            row_reg   <= row_next;
            base_reg  <= base_next;
        end
    end

    assign pos.phase = phase_reg;
    assign pos.col   = col_reg;
    assign pos.row   = row_reg;
    assign pos.idx   = IDX_W'(base_reg + IDX_W'(phase_reg));
    assign pos.wrap  = wrap;

endmodule

>>> rtl/core/lms_rx_ctrl.sv
// ----------------------------------------------------------------------------
// lms_rx_ctrl
// Packet receiver: byte count, header check and display bank selection.
// ----------------------------------------------------------------------------
module lms_rx_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 byte_en,
    input  logic [7:0]           data_byte,
    input  logic                 last_byte,
    output lms_pkg::lms_ram_wr_t wr,
    output lms_pkg::lms_rx_res_t res,
    output logic                 disp_bank,
    output logic                 disp_reset
);
    import lms_pkg::*;

    logic [CNT_W-1:0] byte_count_reg, byte_count_next;
    logic             header_good_reg, header_good_next;
    logic             disp_bank_reg, disp_bank_next;
    logic             disp_reset_reg, disp_reset_next;
    logic             in_range;
    logic             hdr_ok;
    logic [CNT_W-1:0] cnt_inc;
    lms_status_t      status;

    assign in_range = byte_count_reg < CNT_W'(PKT_LEN);
    assign cnt_inc  = in_range ? CNT_W'(byte_count_reg + CNT_W'(1)) : byte_count_reg;
    assign hdr_ok   = header_good_reg &&
                      !(in_range && (byte_count_reg < CNT_W'(HDR_LEN)) &&
                        (data_byte != hdr_byte(byte_count_reg[1:0])));

    always_comb begin
        if (cnt_inc < CNT_W'(PKT_LEN)) begin
            status = ST_SHORT;
        end else if (!hdr_ok) begin
            status = ST_BAD_HDR;
        end else begin
            status = ST_OK;
        end
    end

    always_comb begin
        byte_count_next  = byte_count_reg;
        header_good_next = header_good_reg;
        disp_bank_next   = disp_bank_reg;
        disp_reset_next  = disp_reset_reg;
        if (byte_en) begin
            if (last_byte) begin
                byte_count_next  = '0;
                header_good_next = 1'b1;
                if (status == ST_OK) begin
                    disp_bank_next  = !disp_bank_reg;
                    disp_reset_next = 1'b0;
                end
            end else begin
                byte_count_next  = cnt_inc;
                header_good_next = hdr_ok;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_count_reg  <= '0;
            header_good_reg <= 1'b1;
            disp_bank_reg   <= 1'b0;
            disp_reset_reg  <= 1'b1;
        end else begin
            byte_count_reg  <= byte_count_next;
            header_good_reg <= header_good_next;
            disp_bank_reg   <= disp_bank_next;
            disp_reset_reg  <= disp_reset_next;
        end
    end

    assign wr.en   = byte_en && in_range && (byte_count_reg >= CNT_W'(HDR_LEN));
    assign wr.bank = !disp_bank_reg;
    assign wr.idx  = IDX_W'(byte_count_reg - CNT_W'(HDR_LEN));
    assign wr.data = (data_byte != 8'd0);

    assign res.done   = byte_en && last_byte;
    assign res.status = status;

    assign disp_bank  = disp_bank_reg;
    assign disp_reset = disp_reset_reg;

endmodule

>>> rtl/core/lms_frame_ram.sv
// ----------------------------------------------------------------------------
// lms_frame_ram
// Two-bank frame bit memory, one write port and one registered read port.
// ----------------------------------------------------------------------------
module lms_frame_ram (
    input  logic                 aclk,
    input  lms_pkg::lms_ram_wr_t wr,
    input  logic                 rd_en,
    input  logic                 rd_bank,
    input  logic [lms_pkg::IDX_W-1:0] rd_idx,
    output logic                 rd_data
);
    import lms_pkg::*;

    localparam int DEPTH  = 2 * FRAME_BITS;
    localparam int ADDR_W = $clog2(DEPTH);

    logic             mem [DEPTH];
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] rd_addr;
    logic             rd_data_reg;

    assign wr_addr = wr.bank ? ADDR_W'(FRAME_BITS + int'(wr.idx)) : ADDR_W'(wr.idx);
    assign rd_addr = rd_bank ? ADDR_W'(FRAME_BITS + int'(rd_idx)) : ADDR_W'(rd_idx);

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr_addr] <= wr.data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/core/rgb_led_matrix_scan_driver.sv
// ----------------------------------------------------------------------------
// rgb_led_matrix_scan_driver
// Scan driver for an RGB LED matrix on a shared bus with four latch strobes.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Sideband            Payload
//  s_        in         tuser = mode        tdata[7:0] = data_byte, tlast = last_byte
//  m_        out        tuser = is_status   tdata = bus, strobe, status; tlast = scan_wrap
//
//  One item is accepted in every cycle while s_tready is high; its result goes
//  from the read stage into the m_ register when that register is free or is
//  being read out. The read stage covers the registered frame memory read.
//  Reset is synchronous and active low; the display then shows all pixels red
//  until the first good frame arrives.
//  A stalled m_ side holds the pipeline stage behind it; s_tready drops only
//  when both the output register and the read stage are full.
//
module rgb_led_matrix_scan_driver (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tuser,   // [0] mode
    input  logic        s_tlast,   // last_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] bus_value, [9:8] strobe_select,
                                   // [11:10] packet_status, [15:12] zero
    output logic        m_tuser,   // [0] is_status
    output logic        m_tlast    // scan_wrap
);
    import lms_pkg::*;

`include "assert_macros.svh"

    logic          accept;
    logic          tick;
    logic          byte_en;
    lms_scan_pos_t pos;
    lms_ram_wr_t   wr;
    lms_rx_res_t   rx_res;
    logic          disp_bank;
    logic          disp_reset;
    logic          rd_data;
    logic          m_load;

    // Read stage: holds the result of an item while its frame bit is read.
    logic          p1_valid_reg, p1_valid_next;
    logic          p1_is_status_reg;
    lms_status_t   p1_status_reg;
    lms_strobe_t   p1_phase_reg;
    logic [POS_W-1:0] p1_col_reg;
    logic [POS_W-1:0] p1_row_reg;
    logic          p1_wrap_reg;
    logic          p1_disp_reset_reg;

    // Output register.
    logic          m_valid_reg, m_valid_next;
    logic [15:0]   m_data_reg;
    logic          m_user_reg;
    logic          m_last_reg;

    logic          lit;
    logic [15:0]   p1_data;

    assign m_load   = !m_valid_reg || m_tready;
    assign s_tready = !p1_valid_reg || m_load;
    assign accept   = s_tvalid && s_tready;
    assign tick     = accept && (s_tuser == MODE_TICK);
    assign byte_en  = accept && (s_tuser == MODE_BYTE);

    lms_scan_ctr u_scan (
        .aclk    (aclk),
        .aresetn (aresetn),
        .tick    (tick),
        .pos     (pos)
    );

    lms_rx_ctrl u_rx (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .byte_en    (byte_en),
        .data_byte  (s_tdata),
        .last_byte  (s_tlast),
        .wr         (wr),
        .res        (rx_res),
        .disp_bank  (disp_bank),
        .disp_reset (disp_reset)
    );

    // Scan reads come from the display bank while packet bytes go into the
    // other bank; a good frame swaps the banks, so the copy costs nothing.
    lms_frame_ram u_ram (
        .aclk    (aclk),
        .wr      (wr),
        .rd_en   (tick),
        .rd_bank (disp_bank),
        .rd_idx  (pos.idx),
        .rd_data (rd_data)
    );

    always_comb begin
        p1_valid_next = p1_valid_reg;
        if (accept) begin
            p1_valid_next = tick || rx_res.done;
        end else if (m_load) begin
            p1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
        end else begin
            p1_valid_reg <= p1_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            p1_is_status_reg  <= byte_en;
            p1_status_reg     <= rx_res.status;
            p1_phase_reg      <= pos.phase;
            p1_col_reg        <= pos.col;
            p1_row_reg        <= pos.row;
            p1_wrap_reg       <= pos.wrap;
            p1_disp_reset_reg <= disp_reset;
        end
    end

    // Until the first good frame the display reads as all red.
    assign lit = p1_disp_reset_reg ? (p1_phase_reg == STB_RED) : rd_data;

    always_comb begin
        if (p1_is_status_reg) begin
            p1_data = {4'd0, p1_status_reg, 2'd0, 8'd0};
        end else begin
            p1_data = {4'd0, ST_OK, p1_phase_reg,
                       bus_levels(p1_phase_reg, p1_col_reg, p1_row_reg, lit)};
        end
    end

    assign m_valid_next = m_load ? p1_valid_reg : m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (m_load && p1_valid_reg) begin
            m_data_reg <= p1_data;
            m_user_reg <= p1_is_status_reg;
            m_last_reg <= !p1_is_status_reg && p1_wrap_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;
    assign m_tlast  = m_last_reg;

    // A scan tick always yields a result in the read stage in the next cycle.
    `LMS_ASSERT_NEXT(a_tick_to_p1, tick, p1_valid_reg, "scan tick lost in read stage")
    // A pending result in the read stage is held while the output stalls.
    `LMS_ASSERT_NEXT(a_p1_hold, p1_valid_reg && !m_load, p1_valid_reg && $stable(p1_phase_reg),
                     "read stage dropped a stalled result")
    // An accepted frame leaves the power-up pattern behind for good.
    `LMS_ASSERT_NEXT(a_frame_swap, rx_res.done && byte_en && (rx_res.status == ST_OK),
                     !disp_reset && (disp_bank != $past(disp_bank)),
                     "accepted frame did not swap display bank")
    // Input is refused only when both stages hold results.
    `LMS_ASSERT_SAME(a_ready_full, !s_tready, p1_valid_reg && m_valid_reg,
                     "input stalled with a free stage")

endmodule

>>> sim/rgb_led_matrix_scan_driver_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_led_matrix_scan_driver_tb
// Self-checking bench for the LED matrix scan driver. Scan ticks and packet
// bytes are streamed in with random gaps while the result side stalls at
// random. A scoreboard tracks the scan position, the shown frame and the
// packet receiver, and checks every output transfer field by field.
// ----------------------------------------------------------------------------
module rgb_led_matrix_scan_driver_tb;
    import lms_pkg::*;

    localparam int SCAN_STEPS  = 4 * MATRIX_SIZE * MATRIX_SIZE;
    localparam int ITEM_TARGET = 1950;
    localparam int MAX_ERR_LINES = 50;

    // Frame header "BPSW", first byte in the lowest bits.
    localparam logic [31:0] HDR_WORD = {8'h57, 8'h53, 8'h50, 8'h42};

    // One output transfer as the block should present it.
    typedef struct packed {
        logic        is_status;
        logic [7:0]  bus;
        lms_strobe_t strobe;
        lms_status_t status;
        logic        wrap;
    } matrix_word_t;

    // Scoreboard: keeps its own copy of the scan position, the shown frame
    // and the receive buffer, and queues the words the block owes us.
    class scan_scoreboard;
        int unsigned           step_pos;
        logic [FRAME_BITS-1:0] shown_bits;
        logic [FRAME_BITS-1:0] rx_bits;
        int unsigned           rx_count;
        bit                    hdr_ok;
        matrix_word_t          owed_words[$];
        int                    errors;

        function new();
            step_pos = 0;
            rx_count = 0;
            hdr_ok   = 1'b1;
            rx_bits  = '0;
            errors   = 0;
            // Every pixel shows red after reset.
            for (int i = 0; i < FRAME_BITS; i++)
                shown_bits[i] = ((i % 3) == 0);
        endfunction

        function int pending();
            return owed_words.size();
        endfunction

        task report(input string msg);
            errors++;
            if (errors <= MAX_ERR_LINES)
                $display("ERROR at %0t: %s", $time, msg);
        endtask

        // Called for every accepted input transfer.
        function void note_transfer(input logic mode, input logic [7:0] data,
                                    input logic last);
            matrix_word_t w;
            int unsigned  phase;
            int unsigned  col;
            int unsigned  row;
            int unsigned  idx;
            w = '0;
            if (mode == MODE_TICK) begin
                phase = step_pos % 4;
                col   = (step_pos / 4) % MATRIX_SIZE;
                row   = step_pos / (4 * MATRIX_SIZE);
                if (row >= MATRIX_SIZE)
                    row = MATRIX_SIZE - 1;
                idx      = (row * MATRIX_SIZE + col) * 3 + phase;
                w.strobe = lms_strobe_t'(phase[1:0]);
                w.wrap   = (step_pos == SCAN_STEPS - 1);
                // Color phases pull the pixel's column low when lit; the row
                // phase drives only the row line high.
                for (int k = 0; k < 8; k++) begin
                    if (phase == 3)
                        w.bus[k] = (row == k);
                    else
                        w.bus[k] = (k < MATRIX_SIZE) && !(col == k && shown_bits[idx]);
                end
                step_pos = w.wrap ? 0 : step_pos + 1;
            end else begin
                // Bytes past the full packet length are dropped.
                if (rx_count < PKT_LEN) begin
                    if (rx_count < HDR_LEN) begin
                        if (data != HDR_WORD[8*rx_count +: 8])
                            hdr_ok = 1'b0;
                    end else begin
                        rx_bits[rx_count - HDR_LEN] = (data != 8'h00);
                    end
                    rx_count++;
                end
                if (!last)
                    return;
                w.is_status = 1'b1;
                // Short wins over a bad header when both are wrong.
                if (rx_count < PKT_LEN) begin
                    w.status = ST_SHORT;
                end else if (!hdr_ok) begin
                    w.status = ST_BAD_HDR;
                end else begin
                    w.status   = ST_OK;
                    shown_bits = rx_bits;
                end
                rx_count = 0;
                hdr_ok   = 1'b1;
            end
            owed_words.push_back(w);
        endfunction

        // Called for every accepted output transfer.
        task check_transfer(input logic user, input logic [15:0] word, input logic last);
            matrix_word_t w;
            if (owed_words.size() == 0) begin
                report($sformatf("output transfer with nothing owed: tuser=%b tdata=%h tlast=%b",
                                 user, word, last));
                return;
            end
            w = owed_words.pop_front();
            if (user !== w.is_status)
                report($sformatf("is_status got %b want %b", user, w.is_status));
            if (word[7:0] !== w.bus)
                report($sformatf("bus_value got %h want %h", word[7:0], w.bus));
            if (word[9:8] !== w.strobe)
                report($sformatf("strobe_select got %0d want %0d", word[9:8], w.strobe));
            if (word[11:10] !== w.status)
                report($sformatf("packet_status got %0d want %0d", word[11:10], w.status));
            if (word[15:12] !== 4'h0)
                report($sformatf("tdata padding got %h want 0", word[15:12]));
            if (last !== w.wrap)
                report($sformatf("scan_wrap got %b want %b", last, w.wrap));
        endtask
    endclass

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tuser;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;

    scan_scoreboard sb;
    int             items_sent  = 0;
    bit             src_steady  = 1'b0;   // no input gaps while set
    int             sink_hold   = 0;

    rgb_led_matrix_scan_driver u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #1 aclk = ~aclk;

    // Result side back-pressure: short stalls mostly, now and then a long
    // one, and long ready runs that give stall-free stretches.
    always @(negedge aclk) begin
        if (sink_hold != 0) begin
            sink_hold = sink_hold - 1;
        end else if (m_tready && $urandom_range(0, 3) != 0) begin
            m_tready <= 1'b0;
            sink_hold = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30)
                                                    : $urandom_range(0, 2);
        end else begin
            m_tready <= 1'b1;
            sink_hold = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                    : $urandom_range(0, 20);
        end
    end

    // Every output transfer is checked at the edge that completes it.
    always @(posedge aclk) begin
        if (aresetn === 1'b1 && m_tvalid === 1'b1 && m_tready === 1'b1)
            sb.check_transfer(m_tuser, m_tdata, m_tlast);
    end

    function automatic int pick_gap();
        int r;
        if (src_steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Presents one item and returns at the falling edge after its transfer.
    task automatic send_item(input logic mode, input logic [7:0] data, input logic last);
        int gap;
        gap = pick_gap();
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= data;
        s_tlast  <= last;
        do @(posedge aclk); while (s_tready !== 1'b1);
        sb.note_transfer(mode, data, last);
        items_sent++;
        @(negedge aclk);
    endtask

    // Data and last are don't-care on a tick, so they carry noise.
    task automatic send_tick();
        send_item(MODE_TICK, 8'($urandom), 1'($urandom));
    endtask

    // Sends a datagram of len bytes: the proper header, then color bytes
    // with a per-frame lit density. A header byte at bad_pos is corrupted.
    // Scan ticks are sprinkled in after bytes at random.
    task automatic send_packet(input int len, input int bad_pos);
        logic [7:0] b;
        int         lit_pct;
        lit_pct = $urandom_range(0, 100);
        for (int k = 0; k < len; k++) begin
            if (k < HDR_LEN)
                b = HDR_WORD[8*k +: 8];
            else if ($urandom_range(0, 99) < lit_pct)
                b = 8'($urandom_range(1, 255));
            else
                b = 8'h00;
            if (k == bad_pos)
                b = b ^ 8'($urandom_range(1, 255));
            send_item(MODE_BYTE, b, k == len - 1);
            if ($urandom_range(0, 15) == 0)
                repeat ($urandom_range(1, 3)) send_tick();
        end
    endtask

    // Holds the input side idle until every owed result has come out.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        @(negedge aclk);
    endtask

    initial begin
        int pick;
        sb       = new();
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = 8'h00;
        s_tuser  = MODE_TICK;
        s_tlast  = 1'b0;
        m_tready = 1'b0;
        repeat (10) @(negedge aclk);
        aresetn = 1'b1;

        // First pixel through red, green, blue and row; red is lit at reset.
        repeat (4) send_tick();
        // Datagram of a single byte: too short.
        send_item(MODE_BYTE, 8'h00, 1'b1);
        // Too short and a bad header at once: short is reported.
        send_item(MODE_BYTE, 8'hFF, 1'b0);
        send_item(MODE_BYTE, 8'h50, 1'b0);
        send_item(MODE_BYTE, 8'h00, 1'b1);
        // Ticks while a packet is half received leave the packet receiver alone.
        send_item(MODE_BYTE, 8'h42, 1'b0);
        send_tick();
        send_item(MODE_BYTE, 8'h50, 1'b0);
        send_tick();
        send_item(MODE_BYTE, 8'h53, 1'b1);
        // Ticks with the ignored fields at both extremes.
        send_item(MODE_TICK, 8'hFF, 1'b1);
        send_item(MODE_TICK, 8'h00, 1'b0);
        wait_drained();

        // Random part: mostly well-formed frames and tick bursts, plus bad
        // headers, overlong and short datagrams and plain noise.
        while (items_sent < ITEM_TARGET) begin
            if ($urandom_range(0, 3) == 0)
                src_steady = ~src_steady;
            if ($urandom_range(0, 19) == 0)
                wait_drained();
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                repeat ($urandom_range(20, 150)) send_tick();
            end else if (pick < 65) begin
                send_packet(PKT_LEN, -1);
            end else if (pick < 71) begin
                send_packet(PKT_LEN, int'($urandom_range(0, HDR_LEN - 1)));
            end else if (pick < 78) begin
                send_packet(PKT_LEN + int'($urandom_range(1, 12)),
                            ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 3)) : -1);
            end else if (pick < 85) begin
                send_packet(int'($urandom_range(1, 12)), -1);
            end else if (pick < 92) begin
                send_packet(PKT_LEN - int'($urandom_range(1, 3)), -1);
            end else begin
                repeat ($urandom_range(1, 20))
                    send_item(1'($urandom), 8'($urandom), $urandom_range(0, 9) == 0);
            end
        end
        s_tvalid <= 1'b0;

        while (sb.pending() != 0) @(posedge aclk);
        // Waiting on past the drain catches any stray output transfer.
        repeat (8) @(posedge aclk);
        if (sb.errors == 0) begin
            $display("** rgb_led_matrix_scan_driver: PASSED **");
        end else begin
            $display("** rgb_led_matrix_scan_driver: FAILED **");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin
        #2_000_000;
        $display("Timeout with %0d results still owed", sb.pending());
        $display("** rgb_led_matrix_scan_driver: FAILED **");
        $finish;
    end

endmodule

>>> rgb_led_matrix_scan_driver.f
+incdir+rtl/core
rtl/core/lms_pkg.sv
rtl/core/lms_scan_ctr.sv
rtl/core/lms_rx_ctrl.sv
rtl/core/lms_frame_ram.sv
rtl/core/rgb_led_matrix_scan_driver.sv
sim/rgb_led_matrix_scan_driver_tb.sv
